// ===== rtl/core/mm4_pkg.sv =====
// Shared constants and interface structs for the 4x4 fixed-point matrix multiplier.
// Used by every module of the core; depends on nothing.
package mm4_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int CELLS     = DIM * DIM;
  localparam int CELL_W    = $clog2(CELLS);
  localparam int IDX_W     = $clog2(DIM);
  localparam int LOAD_W    = $clog2(2 * CELLS);
  localparam int ACC_W     = PROD_W + $clog2(DIM);
  localparam int OUT_IDX_W = 2;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic                     en;
    logic                     right;
    logic                     bank;
    logic [CELL_W-1:0]        addr;
    logic signed [ELEM_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic              bank;
    logic [CELL_W-1:0] left_cell;
    logic [CELL_W-1:0] right_cell;
  } store_rd_t;

endpackage

// ===== rtl/core/mm4_front.sv =====
// Load side: counts incoming elements and writes them into the current bank.
// Hands a finished bank to the job queue. Depends on mm4_pkg.
module mm4_front
  import mm4_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [ELEM_W-1:0] s_axis_tdata,
  input  logic              q_full,
  output logic              q_push,
  output logic              q_bank,
  output store_wr_t         wr
);

  logic [LOAD_W-1:0] load_count;
  logic              bank;
  logic              accept;
  logic              last_load;
  logic              is_right;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign last_load     = load_count == LOAD_W'(2 * CELLS - 1);
  assign is_right      = load_count >= LOAD_W'(CELLS);
  assign q_push        = accept && last_load;
  assign q_bank        = bank;

  always_comb begin
    wr.en    = accept;
    wr.right = is_right;
    wr.bank  = bank;
    wr.addr  = is_right ? CELL_W'(load_count - LOAD_W'(CELLS)) : CELL_W'(load_count);
    wr.data  = s_axis_tdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      bank       <= 1'b0;
    end else if (accept) begin
      if (last_load) begin
        load_count <= '0;
        bank       <= ~bank;
      end else begin
        load_count <= load_count + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/mm4_queue.sv =====
// Two-entry job queue carrying the bank number of each fully loaded matrix pair.
// Sits between the load side and the compute side. Depends on mm4_pkg.
module mm4_queue
  import mm4_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic push_bank,
  output logic full,
  input  logic pop,
  output logic valid,
  output logic head_bank
);

  logic       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;

  assign valid     = count != 2'd0;
  assign full      = count == 2'd2;
  assign head_bank = slot[rd_ptr];

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_bank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

endmodule

// ===== rtl/core/mm4_store.sv =====
// Two-bank storage for the left and right matrices, one write and one read port each.
// Read data is registered. Depends on mm4_pkg.
module mm4_store
  import mm4_pkg::*;
(
  input  logic                     clk,
  input  store_wr_t                wr,
  input  store_rd_t                rd,
  output logic signed [ELEM_W-1:0] left_q,
  output logic signed [ELEM_W-1:0] right_q
);

  logic signed [ELEM_W-1:0] left_mem  [2][CELLS];
  logic signed [ELEM_W-1:0] right_mem [2][CELLS];

  always_ff @(posedge clk) begin
    if (wr.en && !wr.right) begin
      left_mem[wr.bank][wr.addr] <= wr.data;
    end
    left_q <= left_mem[rd.bank][rd.left_cell];
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.right) begin
      right_mem[wr.bank][wr.addr] <= wr.data;
    end
    right_q <= right_mem[rd.bank][rd.right_cell];
  end

endmodule

// ===== rtl/core/mm4_back.sv =====
// Compute side: one shared multiplier and accumulator walk row, column and term,
// then shift, saturate and buffer each product element. Depends on mm4_pkg.
module mm4_back
  import mm4_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  input  logic                     q_bank,
  output logic                     q_pop,
  output store_rd_t                rd,
  input  logic signed [ELEM_W-1:0] left_q,
  input  logic signed [ELEM_W-1:0] right_q,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [ELEM_W-1:0]        m_axis_tdata,
  output logic                     m_axis_tlast,
  output logic [4:0]               m_axis_tuser
);

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             run_last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mac_tag_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] value;
    logic [OUT_IDX_W-1:0]     row;
    logic [OUT_IDX_W-1:0]     col;
    logic                     sat;
    logic                     last;
  } result_t;

  logic [IDX_W-1:0]        row;
  logic [IDX_W-1:0]        col;
  logic [IDX_W-1:0]        term;
  logic [OUT_CNT_W-1:0]    reserved;
  logic [OUT_CNT_W-1:0]    reserved_next;
  logic                    issue;
  logic                    term_last;
  logic                    col_last;
  logic                    row_last;
  logic                    run_end;
  logic                    out_pop;
  mac_tag_t                tag0;
  mac_tag_t                tag1;
  mac_tag_t                tag2;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] shifted;
  logic [ACC_W-ELEM_W:0]   upper;
  logic                    fits;
  logic                    done_valid;
  logic [IDX_W-1:0]        done_row;
  logic [IDX_W-1:0]        done_col;
  logic                    done_last;
  result_t                 result;
  result_t                 fifo_mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]    fifo_wr_ptr;
  logic [OUT_PTR_W-1:0]    fifo_rd_ptr;
  logic [OUT_CNT_W-1:0]    fifo_count;
  logic [OUT_CNT_W-1:0]    fifo_count_next;

  // A new element starts only when a slot in the result buffer is reserved for it.
  assign term_last = term == IDX_W'(DIM - 1);
  assign col_last  = col == IDX_W'(DIM - 1);
  assign row_last  = row == IDX_W'(DIM - 1);
  assign run_end   = term_last && col_last && row_last;
  assign issue     = q_valid && (term != '0 || reserved < OUT_CNT_W'(OUT_DEPTH));
  assign q_pop     = issue && run_end;
  assign out_pop   = m_axis_tvalid && m_axis_tready;

  always_comb begin
    rd.bank       = q_bank;
    rd.left_cell  = CELL_W'(row * DIM + term);
    rd.right_cell = CELL_W'(term * DIM + col);
    tag0.valid    = issue;
    tag0.first    = term == '0;
    tag0.last     = term_last;
    tag0.run_last = run_end;
    tag0.row      = row;
    tag0.col      = col;
  end

  always_comb begin
    unique case ({issue && term == '0, out_pop})
      2'b10:   reserved_next = reserved + 1'b1;
      2'b01:   reserved_next = reserved - 1'b1;
      default: reserved_next = reserved;
    endcase
    unique case ({done_valid, out_pop})
      2'b10:   fifo_count_next = fifo_count + 1'b1;
      2'b01:   fifo_count_next = fifo_count - 1'b1;
      default: fifo_count_next = fifo_count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= '0;
      col      <= '0;
      term     <= '0;
      reserved <= '0;
    end else begin
      reserved <= reserved_next;
      if (issue) begin
        term <= term_last ? '0 : term + 1'b1;
        if (term_last) begin
          col <= col_last ? '0 : col + 1'b1;
          if (col_last) begin
            row <= row_last ? '0 : row + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1       <= '0;
      tag2       <= '0;
      done_valid <= 1'b0;
    end else begin
      tag1       <= tag0;
      tag2       <= tag1;
      done_valid <= tag2.valid && tag2.last;
    end
  end

  always_ff @(posedge clk) begin
    prod <= left_q * right_q;
    if (tag2.valid) begin
      acc <= tag2.first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
    done_row  <= tag2.row;
    done_col  <= tag2.col;
    done_last <= tag2.run_last;
  end

  // The shift floors; the sum fits when the result's sign bit and all bits above it agree.
  always_comb begin
    shifted = acc >>> FRAC_BITS;
    upper   = shifted[ACC_W-1:ELEM_W-1];
    fits    = (&upper) || !(|upper);
    if (fits) begin
      result.value = shifted[ELEM_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      result.value = {1'b1, {(ELEM_W - 1){1'b0}}};
    end else begin
      result.value = {1'b0, {(ELEM_W - 1){1'b1}}};
    end
    result.row  = OUT_IDX_W'(done_row);
    result.col  = OUT_IDX_W'(done_col);
    result.sat  = !fits;
    result.last = done_last;
  end

  always_ff @(posedge clk) begin
    if (done_valid) begin
      fifo_mem[fifo_wr_ptr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_wr_ptr <= '0;
      fifo_rd_ptr <= '0;
      fifo_count  <= '0;
    end else begin
      if (done_valid) begin
        fifo_wr_ptr <= fifo_wr_ptr + 1'b1;
      end
      if (out_pop) begin
        fifo_rd_ptr <= fifo_rd_ptr + 1'b1;
      end
      fifo_count <= fifo_count_next;
    end
  end

  assign m_axis_tvalid = fifo_count != '0;
  assign m_axis_tdata  = fifo_mem[fifo_rd_ptr].value;
  assign m_axis_tlast  = fifo_mem[fifo_rd_ptr].last;
  assign m_axis_tuser  = {fifo_mem[fifo_rd_ptr].sat, fifo_mem[fifo_rd_ptr].col,
                          fifo_mem[fifo_rd_ptr].row};

endmodule

// ===== rtl/core/matrix_multiply_4x4_core.sv =====
// Top level of the 4x4 Q16.16 matrix multiplier: load side, job queue, two-bank
// storage and compute side. Depends on mm4_pkg and the mm4_* modules.
//
// Channel   Direction  Payload
// s_axis    in         tdata: element_value (32, signed)
// m_axis    out        tdata: product_value (32, signed); tlast: last_of_run;
//                      tuser: row_index, column_index, was_saturated
//
// 32 transfers fill one bank.
// Each product matrix takes 64 multiplications on the single shared multiplier; each term
// passes the registered store read, the product register and the accumulator.
// Two banks let the next load proceed while the compute side works on the last one.
// Reset clears the load count, the job queue and the result buffer.
// Input stalls only while both banks wait for the compute side; output stalls
// hold the compute side once the four-entry result buffer is reserved.
module matrix_multiply_4x4_core
  import mm4_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] element_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] product_value
  output logic        m_axis_tlast,
  output logic [4:0]  m_axis_tuser   // [1:0] row_index, [3:2] column_index, [4] was_saturated
);

  logic                     q_full;
  logic                     q_push;
  logic                     q_push_bank;
  logic                     q_valid;
  logic                     q_bank;
  logic                     q_pop;
  store_wr_t                wr;
  store_rd_t                rd;
  logic signed [ELEM_W-1:0] left_q;
  logic signed [ELEM_W-1:0] right_q;

  mm4_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_bank        (q_push_bank),
    .wr            (wr)
  );

  mm4_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_bank (q_push_bank),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head_bank (q_bank)
  );

  mm4_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .left_q  (left_q),
    .right_q (right_q)
  );

  mm4_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_bank        (q_bank),
    .q_pop         (q_pop),
    .rd            (rd),
    .left_q        (left_q),
    .right_q       (right_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Stream testbench for matrix_multiply_4x4_core: loads pairs of Q16.16 matrices and checks
// every product element against a predictor kept in this file. Depends on mm4_pkg and the RTL.
module testbench;
  import mm4_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam logic signed [31:0] ELEM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ELEM_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

  typedef enum int {MIX_FULL, MIX_SMALL, MIX_BLEND} value_mix_t;

  typedef struct {
    logic signed [31:0] product;
    logic [1:0] row;
    logic [1:0] column;
    logic saturated;
    logic last;
  } product_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic m_axis_tlast;
  logic [4:0] m_axis_tuser;

  logic signed [31:0] pending_elements[$];
  product_entry_t expected_products[$];
  logic signed [31:0] left_cells[CELLS];
  logic signed [31:0] right_cells[CELLS];
  int loaded_count = 0;

  int send_idle_pct = 10;
  int recv_idle_pct = 69;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  bit element_taken = 1'b0;
  int cycle_count = 0;
  int error_count = 0;
  int runs_loaded = 0;
  int products_checked = 0;
  int saturated_seen = 0;
  int input_stalls = 0;

  matrix_multiply_4x4_core uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  always #10 clk = ~clk;

  // Stores one element and, once both matrices are complete, queues the whole product.
  task automatic absorb_element(input logic signed [31:0] value);
    logic signed [63:0] term;
    logic signed [67:0] dot_sum;
    logic signed [67:0] shifted;
    product_entry_t entry;
    if (loaded_count < CELLS) begin
      left_cells[loaded_count] = value;
    end else begin
      right_cells[loaded_count - CELLS] = value;
    end
    loaded_count++;
    if (loaded_count == 2 * CELLS) begin
      loaded_count = 0;
      runs_loaded++;
      for (int i = 0; i < DIM; i++) begin
        for (int j = 0; j < DIM; j++) begin
          dot_sum = '0;
          for (int k = 0; k < DIM; k++) begin
            term = left_cells[i * DIM + k] * right_cells[k * DIM + j];
            dot_sum = dot_sum + term;
          end
          shifted = dot_sum >>> FRAC_BITS;
          entry.saturated = 1'b1;
          if (shifted > 68'sd2147483647) begin
            entry.product = ELEM_MAX;
          end else if (shifted < -68'sd2147483648) begin
            entry.product = ELEM_MIN;
          end else begin
            entry.product = shifted[31:0];
            entry.saturated = 1'b0;
          end
          entry.row = 2'(i);
          entry.column = 2'(j);
          entry.last = (i == DIM - 1) && (j == DIM - 1);
          expected_products.push_back(entry);
        end
      end
    end
  endtask

  function automatic logic signed [31:0] random_element(input value_mix_t mix);
    logic signed [31:0] small_value;
    small_value = 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
    case (mix)
      MIX_FULL: return $urandom;
      MIX_SMALL: return small_value;
      default: begin
        case ($urandom_range(0, 4))
          0: return $urandom;
          1: return '0;
          2: return ($urandom_range(0, 1) == 1) ? ELEM_MAX : ELEM_MIN;
          default: return small_value;
        endcase
      end
    endcase
  endfunction

  task automatic queue_random_runs(input int run_total);
    value_mix_t mix;
    for (int r = 0; r < run_total; r++) begin
      mix = value_mix_t'($urandom_range(0, 2));
      for (int c = 0; c < 2 * CELLS; c++) begin
        pending_elements.push_back(random_element(mix));
      end
    end
  endtask

  task automatic wait_until_drained();
    while (pending_elements.size() != 0 || s_axis_tvalid || expected_products.size() != 0) begin
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    element_taken = s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && !s_axis_tready) begin
      input_stalls++;
    end
    if (element_taken) begin
      absorb_element(s_axis_tdata);
    end
  end

  always @(posedge clk) begin
    product_entry_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_products.size() == 0) begin
        $error("Unexpected product transfer: tdata=%h tuser=%h", m_axis_tdata, m_axis_tuser);
        error_count++;
      end else begin
        want = expected_products.pop_front();
        products_checked++;
        if (want.saturated) begin
          saturated_seen++;
        end
        if (m_axis_tdata !== want.product) begin
          $error("product_value: expected %h, got %h", want.product, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tuser[1:0] !== want.row) begin
          $error("row_index: expected %0d, got %0d", want.row, m_axis_tuser[1:0]);
          error_count++;
        end
        if (m_axis_tuser[3:2] !== want.column) begin
          $error("column_index: expected %0d, got %0d", want.column, m_axis_tuser[3:2]);
          error_count++;
        end
        if (m_axis_tuser[4] !== want.saturated) begin
          $error("was_saturated: expected %b, got %b", want.saturated, m_axis_tuser[4]);
          error_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_of_run: expected %b, got %b", want.last, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || element_taken) begin
      if (pending_elements.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_elements.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left == 0 && holds_served < hold_requests) begin
      holds_served++;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d products outstanding", cycle_count,
               expected_products.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Saturation in both directions, floor rounding of a sum just below a whole value, and extremes.
    for (int c = 0; c < CELLS; c++) begin
      case (c / DIM)
        0: pending_elements.push_back(ELEM_MAX);
        1: pending_elements.push_back(ELEM_MIN);
        2: pending_elements.push_back((c % DIM == 0) ? -32'sd1 :
                                      (c % DIM == 1) ? 32'sh0001_8000 : 32'sd0);
        default: pending_elements.push_back((c % DIM == 3) ? -ONE_Q16 : 32'sd0);
      endcase
    end
    for (int c = 0; c < CELLS; c++) begin
      case (c % DIM)
        0: pending_elements.push_back(ELEM_MAX);
        1: pending_elements.push_back(ELEM_MIN);
        2: pending_elements.push_back((c / DIM == 0) ? 32'sd1 :
                                      (c / DIM == 1) ? 32'sh0000_8000 : 32'sd0);
        default: pending_elements.push_back(ONE_Q16);
      endcase
    end
    // The identity on the left must pass every right element through unchanged.
    for (int c = 0; c < CELLS; c++) begin
      pending_elements.push_back((c / DIM == c % DIM) ? ONE_Q16 : 32'sd0);
    end
    for (int c = 0; c < CELLS; c++) begin
      case (c % 4)
        0: pending_elements.push_back(ELEM_MIN);
        1: pending_elements.push_back(ELEM_MAX);
        2: pending_elements.push_back(-32'sd1);
        default: pending_elements.push_back((c % 8 == 3) ? 32'sh5555_AAAA : 32'shAAAA_5555);
      endcase
    end
    queue_random_runs(1);
    wait_until_drained();

    send_idle_pct = 69;
    recv_idle_pct = 10;
    queue_random_runs(1);
    wait_until_drained();

    // With no idling, a long output hold-off backs the core up until it refuses input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    queue_random_runs(3);
    wait_until_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Loaded %0d matrix pairs and checked %0d product elements, %0d of them saturated.",
             runs_loaded, products_checked, saturated_seen);
    $display("Input was held back for %0d cycles over %0d clock cycles in total.",
             input_stalls, cycle_count);
    if (error_count == 0 && expected_products.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
